[hw/rtl/ctsc_pkg.sv]
// ----------------------------------------------------------------------------
// ctsc_pkg
// Shared types, codes and helpers of the config token syntax checker.
// ----------------------------------------------------------------------------
package ctsc_pkg;

	// width of the newline counter
	localparam int LINE_BITS    = 20;
	localparam int ERROR_LINE_W = 20;

	// punctuation codes on the result item
	localparam logic [1:0] PUNCT_NONE  = 2'd0;
	localparam logic [1:0] PUNCT_OPEN  = 2'd1;
	localparam logic [1:0] PUNCT_CLOSE = 2'd2;
	localparam logic [1:0] PUNCT_SEMI  = 2'd3;

	// status codes on the result item
	localparam logic [2:0] ST_RUNNING       = 3'd0;
	localparam logic [2:0] ST_VALID         = 3'd1;
	localparam logic [2:0] ST_BAD_CHAR      = 3'd2;
	localparam logic [2:0] ST_UNEXPECTED    = 3'd3;
	localparam logic [2:0] ST_MISSING_CLOSE = 3'd4;
	localparam logic [2:0] ST_MISSING_VALUE = 3'd5;
	localparam logic [2:0] ST_NONE          = 3'd0;

	// grammar states
	localparam logic [1:0] GS_SERVER    = 2'd0;
	localparam logic [1:0] GS_OPEN      = 2'd1;
	localparam logic [1:0] GS_BODY      = 2'd2;
	localparam logic [1:0] GS_DIRECTIVE = 2'd3;

	// token kinds
	localparam logic [2:0] TK_SERVER = 3'd0;
	localparam logic [2:0] TK_WORD   = 3'd1;
	localparam logic [2:0] TK_OPEN   = 3'd2;
	localparam logic [2:0] TK_CLOSE  = 3'd3;
	localparam logic [2:0] TK_SEMI   = 3'd4;

	// characters
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_OPEN  = "{";
	localparam logic [7:0] CH_CLOSE = "}";
	localparam logic [7:0] CH_SEMI  = ";";

	// keyword length
	localparam logic [2:0] KW_LEN = 3'd6;

	// input item payload
	typedef struct packed {
		logic [7:0] ch;
		logic       end_marker;
	} text_t;

	// result item payload
	typedef struct packed {
		logic                    word_ended;
		logic [1:0]              punct;
		logic [2:0]              status;
		logic [ERROR_LINE_W-1:0] error_line;
	} result_t;

	// grammar tracker state
	typedef struct packed {
		logic [1:0] gs;
		logic       halted;
		logic [2:0] held;
	} gram_t;

	// characters of the keyword "server"
	function automatic logic [7:0] kw_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = "s";
			3'd1:    c = "e";
			3'd2:    c = "r";
			3'd3:    c = "v";
			3'd4:    c = "e";
			3'd5:    c = "r";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// one token through the grammar; the first error halts the tracker
	function automatic gram_t gram_step(input gram_t g, input logic [2:0] kind);
		gram_t      r;
		logic       ok;
		logic [1:0] nxt;
		r   = g;
		ok  = 1'b0;
		nxt = g.gs;
		if (!g.halted) begin
			unique case (g.gs)
				GS_SERVER: begin
					ok  = (kind == TK_SERVER);
					nxt = GS_OPEN;
				end
				GS_OPEN: begin
					ok  = (kind == TK_OPEN);
					nxt = GS_BODY;
				end
				GS_BODY: begin
					if (kind == TK_CLOSE) begin
						ok  = 1'b1;
						nxt = GS_SERVER;
					end else if (kind == TK_SERVER || kind == TK_WORD) begin
						ok  = 1'b1;
						nxt = GS_DIRECTIVE;
					end
				end
				default: begin
					if (kind == TK_SEMI) begin
						ok  = 1'b1;
						nxt = GS_BODY;
					end else if (kind == TK_SERVER || kind == TK_WORD) begin
						ok  = 1'b1;
						nxt = GS_DIRECTIVE;
					end
				end
			endcase
			if (ok) begin
				r.gs = nxt;
			end else begin
				r.held   = ST_UNEXPECTED;
				r.halted = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

[hw/rtl/ctsc_text_if.sv]
// ----------------------------------------------------------------------------
// ctsc_text_if
// Input channel of the syntax checker: one text byte or end marker per item.
// ----------------------------------------------------------------------------
interface ctsc_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_marker;

	modport source (output valid, output ch, output end_marker, input ready);
	modport sink   (input valid, input ch, input end_marker, output ready);
endinterface

[hw/rtl/ctsc_result_if.sv]
// ----------------------------------------------------------------------------
// ctsc_result_if
// Result channel of the syntax checker: one result item per input item.
// ----------------------------------------------------------------------------
interface ctsc_result_if;
	logic        valid;
	logic        ready;
	logic        word_ended;
	logic [1:0]  punct;
	logic [2:0]  status;
	logic [19:0] error_line;

	modport source (output valid, output word_ended, output punct, output status,
		output error_line, input ready);
	modport sink   (input valid, input word_ended, input punct, input status,
		input error_line, output ready);
endinterface

[hw/rtl/config_token_syntax_checker_top.sv]
// ----------------------------------------------------------------------------
// config_token_syntax_checker_top
// Tokeniser and grammar checker for server config text, one byte per item.
// ----------------------------------------------------------------------------
// Bytes enter on text, one per cycle, and each one gives exactly one result
// item through the input register, then the result register; a new item is
// taken in every cycle while the result side keeps up. The result reports a
// word that ended just before the byte and the punctuation token of the byte.
// An item with end_marker set closes any open word and reports the verdict
// (valid, unexpected token, missing close brace or missing value), then the
// checker returns to its reset state for the next text. After the first
// grammar error every byte reports nothing until the end marker. Newlines are
// counted for bad character reports, which this character set never raises.
module config_token_syntax_checker_top
	import ctsc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	ctsc_text_if.sink     text,
	ctsc_result_if.source result
);

	// input register
	logic        valid_s1;
	text_t       text_s1;

	// result register
	logic        valid_q;
	result_t     res_q;

	// checker state
	gram_t                gram_q;
	logic                 in_word_q;
	logic [2:0]           kw_idx_q;
	logic                 kw_match_q;
	logic [LINE_BITS-1:0] line_q;

	// next-state and result values
	gram_t                gram_n;
	logic                 in_word_n;
	logic [2:0]           kw_idx_n;
	logic                 kw_match_n;
	logic [LINE_BITS-1:0] line_n;
	result_t              res_n;

	logic advance;

	// flow control
	assign advance    = !valid_q || result.ready;
	assign text.ready = !valid_s1 || advance;

	// tokenise and check one byte
	always_comb begin
		logic       is_server;
		logic       space;
		logic [1:0] p;
		logic       word_start;
		logic [2:0] idx0;
		logic       m0;
		gram_t      g;
		gram_n     = gram_q;
		in_word_n  = in_word_q;
		kw_idx_n   = kw_idx_q;
		kw_match_n = kw_match_q;
		line_n     = line_q;
		res_n      = '0;
		is_server  = kw_match_q && (kw_idx_q == KW_LEN);
		space      = ((text_s1.ch >= CH_TAB) && (text_s1.ch <= CH_CR)) ||
			(text_s1.ch == CH_SPACE);
		p          = (text_s1.ch == CH_OPEN)  ? PUNCT_OPEN  :
			(text_s1.ch == CH_CLOSE) ? PUNCT_CLOSE :
			(text_s1.ch == CH_SEMI)  ? PUNCT_SEMI  : PUNCT_NONE;
		word_start = !in_word_q;
		idx0       = word_start ? 3'd0 : kw_idx_q;
		m0         = word_start ? 1'b1 : kw_match_q;
		g          = gram_q;

		if (text_s1.end_marker) begin
			// close an open word, then give the verdict and reset
			if (!gram_q.halted && in_word_q) begin
				res_n.word_ended = 1'b1;
				g = gram_step(g, is_server ? TK_SERVER : TK_WORD);
			end
			if (g.held != ST_NONE) begin
				res_n.status = g.held;
			end else begin
				unique case (g.gs)
					GS_SERVER: res_n.status = ST_VALID;
					GS_BODY:   res_n.status = ST_MISSING_CLOSE;
					default:   res_n.status = ST_MISSING_VALUE;
				endcase
			end
			gram_n.gs     = GS_SERVER;
			gram_n.halted = 1'b0;
			gram_n.held   = ST_NONE;
			in_word_n     = 1'b0;
			kw_idx_n      = 3'd0;
			kw_match_n    = 1'b1;
			line_n        = '0;
		end else begin
			if (!gram_q.halted) begin
				if (!space && p == PUNCT_NONE) begin
					// word character: keep matching the keyword
					in_word_n = 1'b1;
					if (m0 && (idx0 < KW_LEN) && (text_s1.ch == kw_char(idx0))) begin
						kw_idx_n   = idx0 + 3'd1;
						kw_match_n = m0;
					end else begin
						kw_idx_n   = idx0;
						kw_match_n = 1'b0;
					end
				end else begin
					// separator: close the word, then the punctuation token
					if (in_word_q) begin
						res_n.word_ended = 1'b1;
						in_word_n        = 1'b0;
						g = gram_step(g, is_server ? TK_SERVER : TK_WORD);
					end
					if (p != PUNCT_NONE) begin
						res_n.punct = p;
						g = gram_step(g, (p == PUNCT_OPEN) ? TK_OPEN :
							(p == PUNCT_CLOSE) ? TK_CLOSE : TK_SEMI);
					end
					gram_n = g;
				end
			end
			// saturating newline count
			if (text_s1.ch == CH_LF && line_q != {LINE_BITS{1'b1}}) begin
				line_n = line_q + LINE_BITS'(1);
			end
			res_n.status = ST_RUNNING;
		end
		res_n.error_line = (res_n.status == ST_BAD_CHAR) ? ERROR_LINE_W'(line_q) :
			ERROR_LINE_W'(0);
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			text_s1.ch         <= text.ch;
			text_s1.end_marker <= text.end_marker;
		end
	end

	// checker state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			gram_q.gs     <= GS_SERVER;
			gram_q.halted <= 1'b0;
			gram_q.held   <= ST_NONE;
			in_word_q   <= 1'b0;
			kw_idx_q    <= 3'd0;
			kw_match_q  <= 1'b1;
			line_q      <= '0;
		end else if (advance) begin
			valid_q <= valid_s1;
			if (valid_s1) begin
				gram_q     <= gram_n;
				in_word_q  <= in_word_n;
				kw_idx_q   <= kw_idx_n;
				kw_match_q <= kw_match_n;
				line_q     <= line_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res_n;
		end
	end

	// result channel
	assign result.valid      = valid_q;
	assign result.word_ended = res_q.word_ended;
	assign result.punct      = res_q.punct;
	assign result.status     = res_q.status;
	assign result.error_line = res_q.error_line;

endmodule

[hw/rtl/ctsc_checker.sv]
// ----------------------------------------------------------------------------
// ctsc_checker
// Port-level checks on the result channel of the syntax checker.
// ----------------------------------------------------------------------------
module ctsc_checker
	import ctsc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        r_valid,
	input logic        r_ready,
	input logic        r_word_ended,
	input logic [1:0]  r_punct,
	input logic [2:0]  r_status,
	input logic [19:0] r_error_line
);

	// a stalled result item stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_status) && $stable(r_punct) &&
			$stable(r_word_ended) && $stable(r_error_line))
		else $error("result item changed while stalled");

	// a verdict comes only with an end marker, which forms no punctuation
	a_verdict_no_punct: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_status != ST_RUNNING |-> r_punct == PUNCT_NONE)
		else $error("punctuation reported with a verdict");

	// status stays within its codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> r_status == ST_RUNNING || r_status == ST_VALID ||
			r_status == ST_BAD_CHAR || r_status == ST_UNEXPECTED ||
			r_status == ST_MISSING_CLOSE || r_status == ST_MISSING_VALUE)
		else $error("status code out of range");

	// a line number comes only with a bad character report
	a_line_only_bad: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_status != ST_BAD_CHAR |-> r_error_line == 20'd0)
		else $error("error line without bad character");

endmodule

bind config_token_syntax_checker_top ctsc_checker u_ctsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.r_valid      (result.valid),
	.r_ready      (result.ready),
	.r_word_ended (result.word_ended),
	.r_punct      (result.punct),
	.r_status     (result.status),
	.r_error_line (result.error_line)
);

[test/config_token_syntax_checker_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// config_token_syntax_checker_top_tb
// Self-checking bench for the config token syntax checker.
// ----------------------------------------------------------------------------
// Texts are fed one byte per item, each closed by an end marker. A short
// directed set covers the valid, unexpected token and missing value verdicts
// and the odd byte classes. Random texts follow: mostly well-formed server
// blocks with random words, plus corrupted keywords, truncations, stray
// punctuation and raw noise. Every accepted byte is run through a local
// tokeniser and grammar tracker, and each result item is compared field by
// field with the oldest prediction. Sender and receiver idle at random in two
// phases, then run without idling in a third. One test holds the receiver off
// for a long stretch, and another drains between texts.
module config_token_syntax_checker_top_tb;
	import ctsc_pkg::*;

	localparam int          DRAIN_CYCLES = 4;
	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam logic [47:0] KEYWORD      = "server";

	logic clk;
	logic arst_n;

	ctsc_text_if   txt ();
	ctsc_result_if res ();

	config_token_syntax_checker_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (txt),
		.result (res)
	);

	// predicted results, oldest first
	result_t expected_reports[$];

	// tokeniser and grammar state of the predictor
	logic [1:0]           tok_state;
	logic                 word_open;
	logic [2:0]           kw_pos;
	logic                 kw_live;
	logic [LINE_BITS-1:0] newline_count;
	logic [2:0]           held_status;
	logic                 halted_flag;

	// text being assembled for the next send
	logic [7:0] text_buf[$];

	int          send_idle_pct   = 0;
	int          recv_stall_pct  = 0;
	int          hold_off_cycles = 0;
	int          items_sent      = 0;
	int          fail_count      = 0;
	int unsigned cycle_count     = 0;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$error("run limit of %0d cycles reached, %0d results outstanding",
				LIMIT_CYCLES, expected_reports.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic is_space(input logic [7:0] c);
		return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
	endfunction

	function automatic logic [1:0] punct_of(input logic [7:0] c);
		if (c == CH_OPEN)
			return PUNCT_OPEN;
		if (c == CH_CLOSE)
			return PUNCT_CLOSE;
		if (c == CH_SEMI)
			return PUNCT_SEMI;
		return PUNCT_NONE;
	endfunction

	task automatic clear_tracker();
		tok_state     = GS_SERVER;
		word_open     = 1'b0;
		kw_pos        = 3'd0;
		kw_live       = 1'b1;
		newline_count = '0;
		held_status   = ST_NONE;
		halted_flag   = 1'b0;
	endtask

	// one token through the grammar; the first misfit is held and halts
	task automatic grammar_take(input logic [2:0] kind);
		logic       ok;
		logic [1:0] nxt;
		ok  = 1'b0;
		nxt = tok_state;
		if (halted_flag)
			return;
		case (tok_state)
			GS_SERVER: begin
				ok  = (kind == TK_SERVER);
				nxt = GS_OPEN;
			end
			GS_OPEN: begin
				ok  = (kind == TK_OPEN);
				nxt = GS_BODY;
			end
			GS_BODY: begin
				if (kind == TK_CLOSE) begin
					ok  = 1'b1;
					nxt = GS_SERVER;
				end else if (kind == TK_SERVER || kind == TK_WORD) begin
					ok  = 1'b1;
					nxt = GS_DIRECTIVE;
				end
			end
			default: begin
				if (kind == TK_SEMI) begin
					ok  = 1'b1;
					nxt = GS_BODY;
				end else if (kind == TK_SERVER || kind == TK_WORD) begin
					ok  = 1'b1;
					nxt = GS_DIRECTIVE;
				end
			end
		endcase
		if (ok) begin
			tok_state = nxt;
		end else begin
			held_status = ST_UNEXPECTED;
			halted_flag = 1'b1;
		end
	endtask

	task automatic close_word();
		word_open = 1'b0;
		grammar_take((kw_live && kw_pos == KW_LEN) ? TK_SERVER : TK_WORD);
	endtask

	// predicted result of one accepted byte or end marker
	task automatic tokenise_byte(input logic [7:0] c, input logic endm, output result_t r);
		logic [1:0] p;
		r = '0;
		p = punct_of(c);
		if (endm) begin
			if (!halted_flag && word_open) begin
				r.word_ended = 1'b1;
				close_word();
			end
			if (held_status != ST_NONE)
				r.status = held_status;
			else if (tok_state == GS_SERVER)
				r.status = ST_VALID;
			else if (tok_state == GS_BODY)
				r.status = ST_MISSING_CLOSE;
			else
				r.status = ST_MISSING_VALUE;
			clear_tracker();
		end else begin
			if (!halted_flag) begin
				if (!is_space(c) && p == PUNCT_NONE) begin
					// word character: follow the keyword match
					if (!word_open) begin
						word_open = 1'b1;
						kw_pos    = 3'd0;
						kw_live   = 1'b1;
					end
					if (kw_live && kw_pos < KW_LEN && c == KEYWORD[47 - 8*kw_pos -: 8])
						kw_pos++;
					else
						kw_live = 1'b0;
				end else begin
					if (word_open) begin
						r.word_ended = 1'b1;
						close_word();
					end
					if (p != PUNCT_NONE) begin
						r.punct = p;
						grammar_take(p == PUNCT_OPEN ? TK_OPEN :
							p == PUNCT_CLOSE ? TK_CLOSE : TK_SEMI);
					end
				end
			end
			if (c == CH_LF && newline_count != '1)
				newline_count++;
		end
	endtask

	// receiver: random stalls, or a counted hold-off
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result check against the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (res.valid === 1'b1 && res.ready === 1'b1) begin
			if (expected_reports.size() == 0) begin
				$error("result item with no prediction waiting");
				fail_count++;
			end else begin
				want = expected_reports.pop_front();
				if (res.word_ended !== want.word_ended) begin
					$error("word_ended: expected %0d, got %0d", want.word_ended, res.word_ended);
					fail_count++;
				end
				if (res.punct !== want.punct) begin
					$error("punct: expected %0d, got %0d", want.punct, res.punct);
					fail_count++;
				end
				if (res.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res.status);
					fail_count++;
				end
				if (res.error_line !== want.error_line) begin
					$error("error_line: expected %0d, got %0d", want.error_line,
						res.error_line);
					fail_count++;
				end
			end
		end
	end

	// sends one item; entered and left just after a falling edge
	task automatic send_item(input logic [7:0] c, input logic endm);
		result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			txt.valid <= 1'b0;
			@(negedge clk);
		end
		txt.valid      <= 1'b1;
		txt.ch         <= c;
		txt.end_marker <= endm;
		@(posedge clk);
		while (txt.ready !== 1'b1)
			@(posedge clk);
		tokenise_byte(c, endm, r);
		expected_reports.insert(expected_reports.size(), r);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text();
		foreach (text_buf[i])
			send_item(text_buf[i], 1'b0);
		send_item(8'($urandom_range(255)), 1'b1);
		text_buf.delete();
	endtask

	task automatic wait_for_drain();
		txt.valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	// one byte onto the end of the text being assembled
	task automatic append_byte(input logic [7:0] c);
		text_buf.insert(text_buf.size(), c);
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			append_byte(s[i]);
	endtask

	task automatic push_space(input int min_n);
		int n;
		n = $urandom_range(min_n + 2, min_n);
		repeat (n)
			append_byte(($urandom_range(5) == 0) ? CH_SPACE : CH_TAB + 8'($urandom_range(4)));
	endtask

	function automatic logic [7:0] pick_word_char();
		logic [7:0] c;
		do begin
			c = ($urandom_range(1) == 0) ? 8'($urandom_range(122, 97)) : 8'($urandom_range(255));
		end while (is_space(c) || punct_of(c) != PUNCT_NONE);
		return c;
	endfunction

	task automatic push_word();
		int n;
		if ($urandom_range(9) == 0) begin
			push_str("server");
		end else begin
			n = $urandom_range(6, 1);
			repeat (n)
				append_byte(pick_word_char());
		end
	endtask

	// server blocks with random directives, sometimes broken afterwards
	task automatic build_config_text();
		int n_blocks;
		int n_dirs;
		int n_words;
		int pick;
		n_blocks = $urandom_range(3);
		repeat (n_blocks) begin
			push_space(0);
			case ($urandom_range(9))
				0:       push_str("serve");
				1:       push_str("serverx");
				2:       push_word();
				default: push_str("server");
			endcase
			push_space(0);
			append_byte(CH_OPEN);
			n_dirs = $urandom_range(3);
			repeat (n_dirs) begin
				push_space(0);
				n_words = $urandom_range(3, 1);
				for (int w = 0; w < n_words; w++) begin
					if (w != 0)
						push_space(1);
					push_word();
				end
				push_space(0);
				append_byte(CH_SEMI);
			end
			push_space(0);
			append_byte(CH_CLOSE);
		end
		pick = $urandom_range(99);
		if (pick < 12) begin
			// cut short: may leave a block or directive open
			pick = $urandom_range(text_buf.size());
			while (text_buf.size() > pick)
				void'(text_buf.pop_back());
		end else if (pick < 20) begin
			// stray punctuation somewhere
			text_buf.insert($urandom_range(text_buf.size()),
				($urandom_range(2) == 0) ? CH_OPEN : ($urandom_range(1) ? CH_CLOSE : CH_SEMI));
		end else if (pick < 28) begin
			// raw noise over the whole byte range
			text_buf.delete();
			repeat ($urandom_range(16, 1))
				append_byte(8'($urandom_range(255)));
		end
	endtask

	// empty text is valid
	task automatic test_empty_text();
		send_text();
	endtask

	// valid block with tab, newline, a zero byte and a space
	task automatic test_block_with_odd_bytes();
		push_str("server");
		append_byte(CH_TAB);
		push_str("{x");
		append_byte(8'h00);
		append_byte(CH_LF);
		push_str("y ;}");
		send_text();
	endtask

	// stray close brace, then high bytes that must be ignored
	task automatic test_stray_close();
		push_str("}");
		append_byte(8'hFF);
		append_byte(8'h80);
		send_text();
	endtask

	// keyword left open at the end marker: missing value
	task automatic test_keyword_at_end();
		push_str("server");
		send_text();
	endtask

	task automatic test_random_texts(input int n_items);
		int start;
		start = items_sent;
		while (items_sent - start < n_items) begin
			build_config_text();
			send_text();
		end
	endtask

	// receiver holds off while a long text keeps coming
	task automatic test_receiver_hold_off();
		hold_off_cycles = 300;
		push_str("server { listen 8080;\n root /var/www ; index a b c;}\n");
		push_str("server{x;}server { server server; }");
		send_text();
		wait_for_drain();
	endtask

	// sender waits for every result between texts
	task automatic test_drain_between_texts();
		repeat (6) begin
			build_config_text();
			send_text();
			wait_for_drain();
		end
	endtask

	// stimulus sequence
	initial begin
		arst_n         = 1'b0;
		txt.valid      = 1'b0;
		txt.ch         = 8'h00;
		txt.end_marker = 1'b0;
		res.ready      = 1'b0;
		clear_tracker();
		send_idle_pct  = 32;
		recv_stall_pct = 49;
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_text();
		test_block_with_odd_bytes();
		test_stray_close();
		test_keyword_at_end();
		test_random_texts(300);
		test_receiver_hold_off();

		send_idle_pct  = 49;
		recv_stall_pct = 32;
		test_random_texts(300);
		test_drain_between_texts();

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_random_texts(300);

		wait_for_drain();
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
